// ===== sv/bers_pkg.sv =====
package bers_pkg;

    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned SEC_W        = 6;
    localparam int unsigned DVR_W        = 7;
    localparam int unsigned ONE_W        = 17;
    localparam int unsigned FIVE_W       = 20;
    localparam int unsigned FIFTEEN_W    = 21;
    localparam int unsigned STYPE_W      = 4;
    localparam int unsigned ETYPE_W      = 8;

    localparam logic OP_RECORD  = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_TYPE = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_NB,
        ST_WAIT_NB,
        ST_DIV_MOD,
        ST_WAIT_MOD,
        ST_DIV_S,
        ST_WAIT_S,
        ST_ROLL,
        ST_WIPE,
        ST_SPILL_RD,
        ST_SPILL_WR,
        ST_INC_RD,
        ST_INC_WR,
        ST_CUR_RD,
        ST_PRV_RD,
        ST_PRV_CAP,
        ST_DIV_P,
        ST_WAIT_P,
        ST_DIV_C,
        ST_WAIT_C,
        ST_NEXT_X,
        ST_OUT
    } state_t;

endpackage

// ===== sv/bers_ram.sv =====
module bers_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 240
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bers_div.sv =====
module bers_div #(
    parameter int NUM_BUCKETS = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [bers_pkg::TIME_W-1:0]  dividend,
    input  logic                         by_min,
    output logic                         done,
    output logic [bers_pkg::TIME_W-1:0]  quot,
    output logic [bers_pkg::DVR_W-1:0]   rem
);

    // A division by 60 is a shift right by two followed by a division by 15.
    // Division by 15 or by NUM_BUCKETS is a multiply by a rounded-up reciprocal
    // and a shift by 34 bits, which is exact for operands below 2^30.
    localparam int TW    = bers_pkg::TIME_W;
    localparam int DW    = bers_pkg::DVR_W;
    localparam int RSH   = 34;
    localparam int NW    = 30;
    localparam int MW    = 31;
    localparam int PRW   = NW + MW;
    localparam int QW    = PRW - RSH;
    localparam int QDW   = 2 * DW;
    localparam logic [63:0] MIN_REC = ((64'd1 << RSH) + 64'd14) / 64'd15;
    localparam logic [63:0] NB_REC  = ((64'd1 << RSH) + 64'(NUM_BUCKETS - 1))
                                      / 64'(NUM_BUCKETS);
    localparam logic [DW-1:0] MIN_DVR = DW'(bers_pkg::SECS_PER_MIN);
    localparam logic [DW-1:0] NB_DVR  = DW'(NUM_BUCKETS);

    logic              v1_reg, v2_reg, done_reg;
    logic              min_reg, min_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [TW-1:0]     x_reg, x_next;
    logic [PRW-1:0]    prod_reg, prod_next;
    logic [TW-1:0]     quot_reg, quot_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [MW-1:0]     recip;
    logic [DW-1:0]     dvr;
    logic [QW-1:0]     q;
    logic [QDW-1:0]    qd;

    always_comb
    begin
        n_next    = n_reg;
        x_next    = x_reg;
        min_next  = min_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (go)
        begin
            n_next   = by_min ? dividend[TW-1:2] : dividend[NW-1:0];
            x_next   = dividend;
            min_next = by_min;
        end
        recip     = min_reg ? MIN_REC[MW-1:0] : NB_REC[MW-1:0];
        dvr       = min_reg ? MIN_DVR : NB_DVR;
        prod_next = PRW'(n_reg) * PRW'(recip);
        q         = prod_reg[PRW-1:RSH];
        qd        = QDW'(q[DW-1:0]) * QDW'(dvr);
        if (v2_reg)
        begin
            quot_next = TW'(q);
            rem_next  = DW'(x_reg[DW-1:0] - qd[DW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        min_reg  <= min_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/bucketed_event_rate_stats_top.sv =====
// Sliding-window event rate counter with one ring of one-minute buckets per event type.
// A record beat rolls its type's ring to the event minute (the present minute when
// event_time is zero) and bumps the current bucket; a compute beat rolls every type to
// the present minute and returns one beat per type with its 1, 5 and 15 minute counts,
// the last of them marked by m_tlast. All divisions go through one shared divider for
// constant divisors. A record result is offered after two divisions, a roll with any
// bucket clearing and a read and write of the current bucket; a record of an unknown
// type is answered in the next cycle. A compute divides out the present minute and
// second, then per type rolls the ring, clears stale buckets, reads the newest bucket
// and each older one through the divider and offers the output beat. The input is not
// ready until the last result beat is taken. After reset the bucket memory, all
// NUM_TYPES * NUM_BUCKETS entries, is swept to zero before the first beat is taken.
module bucketed_event_rate_stats_top #(
    parameter int NUM_TYPES   = 16,
    parameter int NUM_BUCKETS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // event_type, now_seconds, event_time
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // stat_type, one_minute, five_minute, fifteen_minute
    output logic        m_tuser,   // status
    output logic        m_tlast
);

    localparam int TW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int DEPTH  = NUM_TYPES * NUM_BUCKETS;
    localparam int AW     = $clog2(DEPTH);
    localparam int XN     = (NUM_BUCKETS < 15) ? NUM_BUCKETS : 15;
    localparam logic [31:0] STALE_SPAN = 32'(60 * (NUM_BUCKETS + 1));

    localparam int CW  = bers_pkg::COUNT_W;
    localparam int TMW = bers_pkg::TIME_W;
    localparam int SW  = bers_pkg::SEC_W;
    localparam int PW  = CW + SW;
    localparam int OW  = bers_pkg::ONE_W;
    localparam int FW  = bers_pkg::FIVE_W;
    localparam int QW  = bers_pkg::FIFTEEN_W;

    bers_pkg::state_t state_reg, state_next;

    logic [TMW-1:0]  start_reg;
    logic            op_reg, op_next;
    logic [7:0]      ety_reg, ety_next;
    logic [TMW-1:0]  now_reg, now_next;
    logic [TMW-1:0]  evt_reg, evt_next;
    logic [BW-1:0]   nb_reg, nb_next;
    logic [SW-1:0]   s_reg, s_next;
    logic [TW-1:0]   ty_reg, ty_next;
    logic [BW-1:0]   idx_reg, idx_next;
    logic [BW-1:0]   x_reg, x_next;
    logic            wall_reg, wall_next;
    logic            phead_reg, phead_next;
    logic [CW-1:0]   cv_reg, cv_next;
    logic [CW-1:0]   pv_reg, pv_next;
    logic [OW-1:0]   val_reg, val_next;
    logic [OW-1:0]   one_reg, one_next;
    logic [FW-1:0]   five_reg, five_next;
    logic [QW-1:0]   fif_reg, fif_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            ost_reg, ost_next;
    logic [3:0]      otype_reg, otype_next;
    logic [OW-1:0]   oone_reg, oone_next;
    logic [FW-1:0]   ofive_reg, ofive_next;
    logic [QW-1:0]   ofif_reg, ofif_next;
    logic            olast_reg, olast_next;

    logic [CW-1:0]   spill_reg [NUM_TYPES];
    logic [CW-1:0]   spill_next [NUM_TYPES];
    logic [BW-1:0]   head_reg [NUM_TYPES];
    logic [BW-1:0]   head_next [NUM_TYPES];
    logic [TMW-1:0]  touched_reg [NUM_TYPES];
    logic [TMW-1:0]  touched_next [NUM_TYPES];

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [CW-1:0]   ram_wdata, ram_rdata;

    logic            div_go, div_done, div_min;
    logic [TMW-1:0]  div_a, div_q;
    logic [bers_pkg::DVR_W-1:0] div_r;

    logic [BW-1:0]   head_sel, cur_idx, prv_idx, idx_inc;
    logic [AW-1:0]   row_base;
    logic [TMW-1:0]  tsel;
    logic [FW-1:0]   five_sum;
    logic [QW-1:0]   fif_sum;

    bers_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bers_div #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_a),
        .by_min   (div_min),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        head_sel = head_reg[ty_reg];
        cur_idx  = (head_sel >= x_reg) ? BW'(head_sel - x_reg)
                                       : BW'(head_sel + BW'(NUM_BUCKETS) - x_reg);
        prv_idx  = (cur_idx == '0) ? BW'(NUM_BUCKETS - 1) : BW'(cur_idx - 1'b1);
        idx_inc  = (idx_reg == BW'(NUM_BUCKETS - 1)) ? '0 : BW'(idx_reg + 1'b1);
        row_base = AW'(AW'(ty_reg) * AW'(NUM_BUCKETS));
        tsel     = (op_reg == bers_pkg::OP_COMPUTE || evt_reg == '0) ? now_reg : evt_reg;
        five_sum = (x_reg < BW'(5)) ? FW'(five_reg + FW'(val_reg)) : five_reg;
        fif_sum  = QW'(fif_reg + QW'(val_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ety_next   = ety_reg;
        now_next   = now_reg;
        evt_next   = evt_reg;
        nb_next    = nb_reg;
        s_next     = s_reg;
        ty_next    = ty_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        wall_next  = wall_reg;
        phead_next = phead_reg;
        cv_next    = cv_reg;
        pv_next    = pv_reg;
        val_next   = val_reg;
        one_next   = one_reg;
        five_next  = five_reg;
        fif_next   = fif_reg;
        clr_next   = clr_reg;
        ost_next   = ost_reg;
        otype_next = otype_reg;
        oone_next  = oone_reg;
        ofive_next = ofive_reg;
        ofif_next  = ofif_reg;
        olast_next = olast_reg;
        spill_next   = spill_reg;
        head_next    = head_reg;
        touched_next = touched_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(row_base + AW'(idx_reg));
        ram_wdata  = '0;
        ram_raddr  = AW'(row_base + AW'(cur_idx));
        div_go     = 1'b0;
        div_a      = tsel - start_reg;
        div_min    = 1'b1;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            bers_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = AW'(clr_reg + 1'b1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = bers_pkg::ST_IDLE;
                end
            end
            bers_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    ety_next = s_tdata[7:0];
                    now_next = s_tdata[39:8];
                    evt_next = s_tdata[71:40];
                    if (s_tuser == bers_pkg::OP_RECORD && s_tdata[7:0] >= 8'(NUM_TYPES))
                    begin
                        ost_next   = bers_pkg::STATUS_BAD_TYPE;
                        otype_next = '0;
                        oone_next  = '0;
                        ofive_next = '0;
                        ofif_next  = '0;
                        olast_next = 1'b1;
                        state_next = bers_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = bers_pkg::ST_DIV_NB;
                    end
                end
            end
            bers_pkg::ST_DIV_NB:
            begin
                div_go     = 1'b1;
                state_next = bers_pkg::ST_WAIT_NB;
            end
            bers_pkg::ST_WAIT_NB:
            begin
                if (div_done)
                begin
                    state_next = bers_pkg::ST_DIV_MOD;
                end
            end
            bers_pkg::ST_DIV_MOD:
            begin
                div_go     = 1'b1;
                div_a      = div_q;
                div_min    = 1'b0;
                state_next = bers_pkg::ST_WAIT_MOD;
            end
            bers_pkg::ST_WAIT_MOD:
            begin
                if (div_done)
                begin
                    nb_next = BW'(div_r);
                    if (op_reg == bers_pkg::OP_COMPUTE)
                    begin
                        state_next = bers_pkg::ST_DIV_S;
                    end
                    else
                    begin
                        ty_next    = TW'(ety_reg);
                        state_next = bers_pkg::ST_ROLL;
                    end
                end
            end
            bers_pkg::ST_DIV_S:
            begin
                div_go     = 1'b1;
                div_a      = now_reg - start_reg;
                state_next = bers_pkg::ST_WAIT_S;
            end
            bers_pkg::ST_WAIT_S:
            begin
                if (div_done)
                begin
                    s_next     = SW'(div_r);
                    ty_next    = '0;
                    state_next = bers_pkg::ST_ROLL;
                end
            end
            bers_pkg::ST_ROLL:
            begin
                touched_next[ty_reg] = now_reg;
                x_next    = '0;
                one_next  = '0;
                five_next = '0;
                fif_next  = '0;
                if ((now_reg - touched_reg[ty_reg]) >= STALE_SPAN)
                begin
                    spill_next[ty_reg] = '0;
                    head_next[ty_reg]  = nb_reg;
                    idx_next   = '0;
                    wall_next  = 1'b1;
                    state_next = bers_pkg::ST_WIPE;
                end
                else if (nb_reg != head_sel)
                begin
                    idx_next   = (head_sel == BW'(NUM_BUCKETS - 1)) ? '0
                                                                    : BW'(head_sel + 1'b1);
                    wall_next  = 1'b0;
                    state_next = bers_pkg::ST_WIPE;
                end
                else
                begin
                    state_next = (op_reg == bers_pkg::OP_COMPUTE) ? bers_pkg::ST_CUR_RD
                                                                  : bers_pkg::ST_INC_RD;
                end
            end
            bers_pkg::ST_WIPE:
            begin
                if (wall_reg)
                begin
                    ram_we   = 1'b1;
                    idx_next = idx_inc;
                    if (idx_reg == BW'(NUM_BUCKETS - 1))
                    begin
                        state_next = (op_reg == bers_pkg::OP_COMPUTE) ? bers_pkg::ST_CUR_RD
                                                                      : bers_pkg::ST_INC_RD;
                    end
                end
                else if (idx_reg == nb_reg)
                begin
                    state_next = bers_pkg::ST_SPILL_RD;
                end
                else
                begin
                    ram_we   = 1'b1;
                    idx_next = idx_inc;
                end
            end
            bers_pkg::ST_SPILL_RD:
            begin
                ram_raddr  = AW'(row_base + AW'(nb_reg));
                state_next = bers_pkg::ST_SPILL_WR;
            end
            bers_pkg::ST_SPILL_WR:
            begin
                spill_next[ty_reg] = ram_rdata;
                head_next[ty_reg]  = nb_reg;
                ram_we     = 1'b1;
                ram_waddr  = AW'(row_base + AW'(nb_reg));
                state_next = (op_reg == bers_pkg::OP_COMPUTE) ? bers_pkg::ST_CUR_RD
                                                              : bers_pkg::ST_INC_RD;
            end
            bers_pkg::ST_INC_RD:
            begin
                ram_raddr  = AW'(row_base + AW'(head_sel));
                state_next = bers_pkg::ST_INC_WR;
            end
            bers_pkg::ST_INC_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(row_base + AW'(head_sel));
                ram_wdata  = (ram_rdata == '1) ? ram_rdata : CW'(ram_rdata + 1'b1);
                ost_next   = bers_pkg::STATUS_OK;
                otype_next = '0;
                oone_next  = '0;
                ofive_next = '0;
                ofif_next  = '0;
                olast_next = 1'b1;
                state_next = bers_pkg::ST_OUT;
            end
            bers_pkg::ST_CUR_RD:
            begin
                state_next = bers_pkg::ST_PRV_RD;
            end
            bers_pkg::ST_PRV_RD:
            begin
                cv_next    = ram_rdata;
                ram_raddr  = AW'(row_base + AW'(prv_idx));
                phead_next = (prv_idx == head_sel);
                state_next = bers_pkg::ST_PRV_CAP;
            end
            bers_pkg::ST_PRV_CAP:
            begin
                pv_next    = phead_reg ? spill_reg[ty_reg] : ram_rdata;
                state_next = bers_pkg::ST_DIV_P;
            end
            bers_pkg::ST_DIV_P:
            begin
                div_go     = 1'b1;
                div_a      = TMW'(PW'(pv_reg) * PW'(SW'(bers_pkg::SECS_PER_MIN) - s_reg));
                state_next = bers_pkg::ST_WAIT_P;
            end
            bers_pkg::ST_WAIT_P:
            begin
                if (div_done)
                begin
                    if (x_reg == '0)
                    begin
                        val_next   = OW'(OW'(div_q[CW-1:0]) + OW'(cv_reg));
                        state_next = bers_pkg::ST_NEXT_X;
                    end
                    else
                    begin
                        val_next   = OW'(div_q[CW-1:0]);
                        state_next = bers_pkg::ST_DIV_C;
                    end
                end
            end
            bers_pkg::ST_DIV_C:
            begin
                div_go     = 1'b1;
                div_a      = TMW'(PW'(cv_reg) * PW'(s_reg))
                             + TMW'(bers_pkg::SECS_PER_MIN - 1);
                state_next = bers_pkg::ST_WAIT_C;
            end
            bers_pkg::ST_WAIT_C:
            begin
                if (div_done)
                begin
                    val_next   = OW'(val_reg + OW'(div_q[CW-1:0]));
                    state_next = bers_pkg::ST_NEXT_X;
                end
            end
            bers_pkg::ST_NEXT_X:
            begin
                if (x_reg == '0)
                begin
                    one_next = val_reg;
                end
                five_next = five_sum;
                fif_next  = fif_sum;
                if (x_reg == BW'(XN - 1))
                begin
                    ost_next   = bers_pkg::STATUS_OK;
                    otype_next = 4'(ty_reg);
                    oone_next  = (x_reg == '0) ? val_reg : one_reg;
                    ofive_next = five_sum;
                    ofif_next  = fif_sum;
                    olast_next = (ty_reg == TW'(NUM_TYPES - 1));
                    state_next = bers_pkg::ST_OUT;
                end
                else
                begin
                    x_next     = BW'(x_reg + 1'b1);
                    state_next = bers_pkg::ST_CUR_RD;
                end
            end
            bers_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (op_reg == bers_pkg::OP_COMPUTE && ty_reg != TW'(NUM_TYPES - 1))
                    begin
                        ty_next    = TW'(ty_reg + 1'b1);
                        state_next = bers_pkg::ST_ROLL;
                    end
                    else
                    begin
                        state_next = bers_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bers_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bers_pkg::ST_CLEAR;
            start_reg <= '0;
            clr_reg   <= '0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                spill_reg[i]   <= '0;
                head_reg[i]    <= '0;
                touched_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                start_reg <= cfg_data;
            end
            spill_reg   <= spill_next;
            head_reg    <= head_next;
            touched_reg <= touched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ety_reg   <= ety_next;
        now_reg   <= now_next;
        evt_reg   <= evt_next;
        nb_reg    <= nb_next;
        s_reg     <= s_next;
        ty_reg    <= ty_next;
        idx_reg   <= idx_next;
        x_reg     <= x_next;
        wall_reg  <= wall_next;
        phead_reg <= phead_next;
        cv_reg    <= cv_next;
        pv_reg    <= pv_next;
        val_reg   <= val_next;
        one_reg   <= one_next;
        five_reg  <= five_next;
        fif_reg   <= fif_next;
        ost_reg   <= ost_next;
        otype_reg <= otype_next;
        oone_reg  <= oone_next;
        ofive_reg <= ofive_next;
        ofif_reg  <= ofif_next;
        olast_reg <= olast_next;
    end

    assign m_tdata = {2'b00, ofif_reg, ofive_reg, oone_reg, otype_reg};
    assign m_tuser = ost_reg;
    assign m_tlast = olast_reg;

endmodule
